// ===== src/itr_pkg.sv =====
// Shared types, constants and symbol tables for the integer to Roman numeral converter.
package itr_pkg;

    localparam logic [11:0] MaxValue = 12'd3999;
    localparam int          Places   = 4;

    localparam logic [7:0] SymI = 8'h49;
    localparam logic [7:0] SymV = 8'h56;
    localparam logic [7:0] SymX = 8'h58;
    localparam logic [7:0] SymL = 8'h4C;
    localparam logic [7:0] SymC = 8'h43;
    localparam logic [7:0] SymD = 8'h44;
    localparam logic [7:0] SymM = 8'h4D;
    localparam logic [7:0] SymNone = 8'h00;

    localparam logic [1:0] IdxOnes = 2'd0;
    localparam logic [1:0] IdxFive = 2'd1;
    localparam logic [1:0] IdxTen  = 2'd2;

    localparam logic [13:0] Thresh [Places][10] = '{
        '{14'd0, 14'd1, 14'd2, 14'd3, 14'd4, 14'd5, 14'd6, 14'd7, 14'd8, 14'd9},
        '{14'd0, 14'd10, 14'd20, 14'd30, 14'd40, 14'd50, 14'd60, 14'd70, 14'd80, 14'd90},
        '{14'd0, 14'd100, 14'd200, 14'd300, 14'd400, 14'd500, 14'd600, 14'd700, 14'd800,
          14'd900},
        '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000,
          14'd8000, 14'd9000}
    };

    typedef struct packed {
        logic            err;
        logic [3:0][3:0] digits;
    } itr_entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_CONV,
        FR_PUSH
    } itr_front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } itr_back_state_t;

    function automatic logic [2:0] digit_len(logic [3:0] d);
        logic [2:0] n;
        begin
            case (d)
                4'd1:    n = 3'd1;
                4'd2:    n = 3'd2;
                4'd3:    n = 3'd3;
                4'd4:    n = 3'd2;
                4'd5:    n = 3'd1;
                4'd6:    n = 3'd2;
                4'd7:    n = 3'd3;
                4'd8:    n = 3'd4;
                4'd9:    n = 3'd2;
                default: n = 3'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [1:0] digit_pat(logic [3:0] d, logic [1:0] k);
        logic [1:0] idx;
        begin
            case (d)
                4'd4:                   idx = (k == 2'd1) ? IdxFive : IdxOnes;
                4'd5, 4'd6, 4'd7, 4'd8: idx = (k == 2'd0) ? IdxFive : IdxOnes;
                4'd9:                   idx = (k == 2'd1) ? IdxTen : IdxOnes;
                default:                idx = IdxOnes;
            endcase
            return idx;
        end
    endfunction

    function automatic logic [7:0] place_sym(logic [1:0] place, logic [1:0] idx);
        logic [7:0] s;
        begin
            case (place)
                2'd0:    s = (idx == IdxOnes) ? SymI : (idx == IdxFive) ? SymV : SymX;
                2'd1:    s = (idx == IdxOnes) ? SymX : (idx == IdxFive) ? SymL : SymC;
                2'd2:    s = (idx == IdxOnes) ? SymC : (idx == IdxFive) ? SymD : SymM;
                default: s = SymM;
            endcase
            return s;
        end
    endfunction

endpackage

// ===== src/itr_front.sv =====
// Input side: range check and decimal digit extraction, one place per cycle.
module itr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [11:0]         in_value,
    output logic                push,
    output itr_pkg::itr_entry_t push_data,
    input  logic                full
);

    itr_pkg::itr_front_state_t state_reg, state_next;
    logic [11:0]               rem_reg, rem_next;
    logic [1:0]                place_reg, place_next;
    logic                      err_reg, err_next;
    logic [3:0][3:0]           digits_reg, digits_next;
    logic [3:0]                digit;

    always_comb
    begin
        digit = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if ({2'b00, rem_reg} >= itr_pkg::Thresh[place_reg][k])
            begin
                digit = 4'(k);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        rem_next    = rem_reg;
        place_next  = place_reg;
        err_next    = err_reg;
        digits_next = digits_reg;
        in_ready    = 1'b0;
        push        = 1'b0;
        case (state_reg)
            itr_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    rem_next    = in_value;
                    place_next  = 2'd3;
                    digits_next = '0;
                    err_next    = (in_value == 12'd0) || (in_value > itr_pkg::MaxValue);
                    state_next  = err_next ? itr_pkg::FR_PUSH : itr_pkg::FR_CONV;
                end
            end
            itr_pkg::FR_CONV:
            begin
                digits_next[place_reg] = digit;
                rem_next = 12'({2'b00, rem_reg} - itr_pkg::Thresh[place_reg][digit]);
                if (place_reg == 2'd0)
                begin
                    state_next = itr_pkg::FR_PUSH;
                end
                else
                begin
                    place_next = place_reg - 2'd1;
                end
            end
            itr_pkg::FR_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = itr_pkg::FR_IDLE;
                end
            end
            default:
            begin
                state_next = itr_pkg::FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itr_pkg::FR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        place_reg  <= place_next;
        err_reg    <= err_next;
        digits_reg <= digits_next;
    end

    assign push_data.err    = err_reg;
    assign push_data.digits = digits_reg;

endmodule

// ===== src/itr_fifo.sv =====
// Short queue of converted entries between the front and back sides.
module itr_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  itr_pkg::itr_entry_t push_data,
    output logic                full,
    input  logic                pop,
    output itr_pkg::itr_entry_t pop_data,
    output logic                empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    itr_pkg::itr_entry_t mem [DEPTH];
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/itr_back.sv =====
// Output side: walk the digits of one entry and send one numeral character per transfer.
module itr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  itr_pkg::itr_entry_t pop_data,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_symbol,
    output logic                out_last,
    output logic                out_error
);

    itr_pkg::itr_back_state_t state_reg, state_next;
    itr_pkg::itr_entry_t      ent_reg, ent_next;
    logic [1:0]               place_reg, place_next;
    logic [1:0]               k_reg, k_next;
    logic                     out_valid_reg, out_valid_next;
    logic [7:0]               out_symbol_reg, out_symbol_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_error_reg, out_error_next;
    logic                     load_ok;
    logic [3:0]               d;
    logic [2:0]               len;
    logic                     lower_nz;
    logic                     final_k;

    assign load_ok = !out_valid_reg || out_ready;
    assign d       = ent_reg.digits[place_reg];
    assign len     = itr_pkg::digit_len(d);
    assign final_k = ({1'b0, k_reg} == len - 3'd1);

    always_comb
    begin
        lower_nz = 1'b0;
        for (int i = 0; i < itr_pkg::Places; i++)
        begin
            if ((2'(i) < place_reg) && (ent_reg.digits[i] != 4'd0))
            begin
                lower_nz = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ent_next        = ent_reg;
        place_next      = place_reg;
        k_next          = k_reg;
        out_symbol_next = out_symbol_reg;
        out_last_next   = out_last_reg;
        out_error_next  = out_error_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pop             = 1'b0;
        case (state_reg)
            itr_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    ent_next   = pop_data;
                    place_next = 2'd3;
                    k_next     = 2'd0;
                    state_next = itr_pkg::BK_RUN;
                end
            end
            itr_pkg::BK_RUN:
            begin
                if (ent_reg.err)
                begin
                    if (load_ok)
                    begin
                        out_valid_next  = 1'b1;
                        out_symbol_next = itr_pkg::SymNone;
                        out_last_next   = 1'b1;
                        out_error_next  = 1'b1;
                        state_next      = itr_pkg::BK_IDLE;
                    end
                end
                else if (len == 3'd0)
                begin
                    k_next = 2'd0;
                    if (place_reg == 2'd0)
                    begin
                        state_next = itr_pkg::BK_IDLE;
                    end
                    else
                    begin
                        place_next = place_reg - 2'd1;
                    end
                end
                else if (load_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_symbol_next = itr_pkg::place_sym(place_reg,
                                                         itr_pkg::digit_pat(d, k_reg));
                    out_last_next   = final_k && !lower_nz;
                    out_error_next  = 1'b0;
                    if (final_k)
                    begin
                        k_next = 2'd0;
                        if (!lower_nz || (place_reg == 2'd0))
                        begin
                            state_next = itr_pkg::BK_IDLE;
                        end
                        else
                        begin
                            place_next = place_reg - 2'd1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = itr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg        <= ent_next;
        place_reg      <= place_next;
        k_reg          <= k_next;
        out_symbol_reg <= out_symbol_next;
        out_last_reg   <= out_last_next;
        out_error_reg  <= out_error_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_symbol = out_symbol_reg;
    assign out_last   = out_last_reg;
    assign out_error  = out_error_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_error_reg |-> out_last_reg && (out_symbol_reg == itr_pkg::SymNone))
        else $error("error transfer is not a single zero symbol");

    a_sym_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_error_reg |-> out_symbol_reg != itr_pkg::SymNone)
        else $error("numeral transfer carries no symbol");

    a_thousands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itr_pkg::BK_RUN) && !ent_reg.err |-> ent_reg.digits[3] <= 4'd3)
        else $error("thousands digit out of range");

    a_nonzero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itr_pkg::BK_RUN) && !ent_reg.err |-> ent_reg.digits != '0)
        else $error("valid entry has no nonzero digit");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == itr_pkg::BK_IDLE) && !empty)
        else $error("entry taken while busy or queue empty");

endmodule

// ===== src/integer_to_roman_numeral.sv =====
// Top level of the integer to Roman numeral converter.
//
// Slave channel (s_axis): one transfer per integer, value in tdata[11:0].
// Master channel (m_axis): one transfer per numeral character, most significant
// first; tdata is the ASCII code, tlast marks the final character, tuser flags
// a value outside 1 to 3999 (then a single transfer with tdata 0 and tlast 1).
// The front side takes one integer at a time: an accept step, the four digits
// from a compare-and-subtract stage, one place per step, and a queue write; an
// out-of-range value skips the digit steps. The back side fetches an entry, then
// takes one step per character and one per zero digit above the lowest nonzero
// one, and a character step waits while the output stalls; 3888 gives the
// longest numeral. The slower of the two sides sets the sustained rate.
// The queue holds FIFO_DEPTH converted entries so the front side
// keeps accepting while the receiver stalls; when it fills, s_axis_tready drops.
// A stalled output transfer holds its data. Reset clears the state machines,
// queue pointers and count and output valid, and leaves no transfer pending.
module integer_to_roman_numeral #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] symbol
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // [0] error
);

    itr_pkg::itr_entry_t push_data;
    itr_pkg::itr_entry_t pop_data;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;

    itr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_value  (s_axis_tdata[11:0]),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    itr_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    itr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_symbol (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .out_error  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench: random stream traffic into the Roman numeral converter, checked by a predictor.
module tb;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
        logic       error;
    } numeral_char_t;

    typedef struct packed {
        logic [11:0] value;
        logic        drain;
    } pending_value_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [11:0] value, [15:12] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] symbol
    logic        m_axis_tlast;
    logic        m_axis_tuser;         // [0] error

    pending_value_t pending_values[$];
    numeral_char_t  expected_chars[$];
    logic           chars_drained = 1'b1;
    int unsigned    cycle_no = 0;
    int unsigned    mismatch_count = 0;
    logic           steady;

    assign steady = (cycle_no >= 3000) && (cycle_no < 5000);

    integer_to_roman_numeral dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic void push_symbol(logic [7:0] s);
        numeral_char_t c;
        c.symbol = s;
        c.last   = 1'b0;
        c.error  = 1'b0;
        expected_chars.push_back(c);
    endfunction

    function automatic void append_digit(int d, logic [7:0] one, logic [7:0] five,
                                         logic [7:0] ten);
        int k;
        if (d == 9)
        begin
            push_symbol(one);
            push_symbol(ten);
        end
        else if (d == 4)
        begin
            push_symbol(one);
            push_symbol(five);
        end
        else
        begin
            if (d >= 5)
                push_symbol(five);
            for (k = 0; k < d % 5; k++)
                push_symbol(one);
        end
    endfunction

    function automatic void predict_numeral(logic [11:0] v);
        int n;
        numeral_char_t c;
        n = v;
        if (v == 12'd0 || v > itr_pkg::MaxValue)
        begin
            c.symbol = itr_pkg::SymNone;
            c.last   = 1'b1;
            c.error  = 1'b1;
            expected_chars.push_back(c);
        end
        else
        begin
            append_digit(n / 1000, itr_pkg::SymM, itr_pkg::SymM, itr_pkg::SymM);
            append_digit((n / 100) % 10, itr_pkg::SymC, itr_pkg::SymD, itr_pkg::SymM);
            append_digit((n / 10) % 10, itr_pkg::SymX, itr_pkg::SymL, itr_pkg::SymC);
            append_digit(n % 10, itr_pkg::SymI, itr_pkg::SymV, itr_pkg::SymX);
            expected_chars[expected_chars.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void queue_value(logic [11:0] v, logic drain);
        pending_value_t p;
        p.value = v;
        p.drain = drain;
        pending_values.push_back(p);
    endfunction

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycle_no <= 0;
        else
            cycle_no <= cycle_no + 1;
    end

    // hold an item until its transfer; a drain item waits for every expected character
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_values.size() > 0 && (steady || $urandom_range(99) >= 35)
                && (!pending_values[0].drain || (!s_axis_tvalid && chars_drained)))
            begin
                s_axis_tdata  <= {4'b0000, pending_values[0].value};
                s_axis_tvalid <= 1'b1;
                pending_values.delete(0);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(99) >= 35);
    end

    always @(posedge clk or negedge rst_n)
    begin
        numeral_char_t want;
        if (!rst_n)
        begin
            chars_drained <= 1'b1;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_numeral(s_axis_tdata[11:0]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character transfer: symbol %h last %b error %b",
                           m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.symbol)
                    begin
                        $error("symbol mismatch: expected %h, actual %h",
                               want.symbol, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last mismatch: expected %b, actual %b",
                               want.last, m_axis_tlast);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== want.error)
                    begin
                        $error("error mismatch: expected %b, actual %b",
                               want.error, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
            chars_drained <= (expected_chars.size() == 0);
        end
    end

    initial
    begin
        int i;
        int r;
        logic [11:0] v;

        queue_value(12'd1, 1'b0);
        queue_value(12'd3999, 1'b0);
        queue_value(12'd0, 1'b0);
        queue_value(12'd4000, 1'b0);
        queue_value(12'd4095, 1'b0);
        queue_value(12'd3888, 1'b0);
        queue_value(12'd4, 1'b0);
        queue_value(12'd9, 1'b0);
        queue_value(12'd5, 1'b0);
        queue_value(12'd10, 1'b0);
        queue_value(12'd40, 1'b0);
        queue_value(12'd50, 1'b0);
        queue_value(12'd90, 1'b0);
        queue_value(12'd100, 1'b0);
        queue_value(12'd400, 1'b0);
        queue_value(12'd500, 1'b0);
        queue_value(12'd900, 1'b0);
        queue_value(12'd1000, 1'b0);
        queue_value(12'd2000, 1'b0);
        queue_value(12'd3000, 1'b0);
        queue_value(12'd444, 1'b0);
        queue_value(12'd999, 1'b0);
        queue_value(12'd1994, 1'b0);
        queue_value(12'd2768, 1'b0);

        for (i = 0; i < 400; i++)
        begin
            r = $urandom_range(99);
            if (r < 5)
                v = 12'd0;
            else if (r < 10)
                v = 12'($urandom_range(4095, 4000));
            else if (r < 25)
                v = 12'($urandom_range(99, 1));
            else
                v = 12'($urandom_range(3999, 1));
            queue_value(v, (i % 100) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (pending_values.size() != 0 || s_axis_tvalid || expected_chars.size() != 0);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
